@@ design/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg: shared definitions for the quadratic root solver
// Default widths, result width and the sequencer state type.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // Default fraction bits and coefficient width (sign plus magnitude).
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEFF_BITS_DEF = 32;

  // Width of every numeric result.
  localparam int RES_W = 32;

  // Codes of the solved_degree field.
  localparam logic [1:0] DEGREE_ONE = 2'd1;
  localparam logic [1:0] DEGREE_TWO = 2'd2;

  // Codes of the solution_count field.
  localparam logic [1:0] SOL_NONE   = 2'd0;
  localparam logic [1:0] SOL_ONE    = 2'd1;
  localparam logic [1:0] SOL_TWO    = 2'd2;

  // Index of the division under way.
  localparam logic [1:0] DIV_PLUS  = 2'd0;
  localparam logic [1:0] DIV_MINUS = 2'd1;
  localparam logic [1:0] DIV_REAL  = 2'd2;
  localparam logic [1:0] DIV_IMAG  = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DISC,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

endpackage

@@ design/qrs_if.sv @@
// ----------------------------------------------------------------------------
// qrs_if: item channels of the quadratic root solver
// Equation channel and root channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface qrs_in_if #(
  parameter int MAG_W = 31
) ();
  logic             valid;
  logic             ready;
  logic             degree_two;
  logic [1:0]       term_count;
  logic [MAG_W-1:0] lead_magnitude;
  logic             lead_negative;
  logic [MAG_W-1:0] second_magnitude;
  logic             second_negative;
  logic             second_power;
  logic [MAG_W-1:0] third_magnitude;
  logic             third_negative;

  modport source (
    output valid, degree_two, term_count, lead_magnitude, lead_negative,
           second_magnitude, second_negative, second_power,
           third_magnitude, third_negative,
    input  ready
  );
  modport sink (
    input  valid, degree_two, term_count, lead_magnitude, lead_negative,
           second_magnitude, second_negative, second_power,
           third_magnitude, third_negative,
    output ready
  );
endinterface

interface qrs_out_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] root_first;
  logic signed [31:0] root_second;
  logic signed [31:0] real_part;
  logic signed [31:0] imag_part;
  logic               complex_roots;
  logic [1:0]         solution_count;
  logic [1:0]         solved_degree;
  logic               zero_lead;
  logic               saturated;

  modport source (
    output valid, root_first, root_second, real_part, imag_part,
           complex_roots, solution_count, solved_degree, zero_lead, saturated,
    input  ready
  );
  modport sink (
    input  valid, root_first, root_second, real_part, imag_part,
           complex_roots, solution_count, solved_degree, zero_lead, saturated,
    output ready
  );
endinterface

@@ design/qrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt: bit-serial integer square root
// Restoring method, two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CNT_W = $clog2(RW + 1);

  logic            busy;
  logic [CNT_W-1:0] cnt;
  logic [2*RW-1:0] rad;
  logic [RW+2:0]   rem;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic            ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {rem[RW:0], rad[2*RW-1:2*RW-2]};
    trial  = {1'b0, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[2*RW-3:0], 2'b00};
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

@@ design/qrs_div.sv @@
// ----------------------------------------------------------------------------
// qrs_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
  parameter int NW = 50,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    numr;
  logic [DW-1:0]    rem;
  logic [DW:0]      rem_sh;
  logic             ge;
  logic [DW:0]      rem_next;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh   = {rem, numr[NW-1]};
    ge       = rem_sh >= {1'b0, den};
    rem_next = ge ? rem_sh - {1'b0, den} : rem_sh;
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      numr <= num;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      numr <= {numr[NW-2:0], 1'b0};
      rem  <= rem_next[DW-1:0];
      quo  <= {quo[NW-2:0], ge};
    end
  end

endmodule

@@ design/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver: roots of linear and quadratic equations
// Solves one sign-magnitude fixed-point equation per item.
// ----------------------------------------------------------------------------
// Usage: items enter on eqn (valid/ready) and one result per item leaves on
// roots (valid/ready). Only one item is in work at a time; eqn.ready is high
// while the sequencer is idle, even while a finished result still waits.
// Zero leading term or a single-term linear equation: straight to the final step;
// linear: one division; quadratic: serial products, discriminant, square root,
// then two divisions for real roots or four for complex roots.
// The solve time is set by the serial multipliers, the bit-serial square root and
// one shared bit-serial divider that runs once per root figure.
// A new item is taken in the cycle after the result register is loaded.
// Reset empties the result register and returns the sequencer to idle.
// When the receiver stalls, the result is held and the next item waits in
// its final step until the result register frees.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COEFF_BITS = COEFF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qrs_in_if.sink    eqn,
  qrs_out_if.source roots
);

  localparam int MAG_W  = COEFF_BITS - 1;
  localparam int PW     = 2 * MAG_W;
  localparam int RW     = MAG_W + 2;
  localparam int RAD_W  = 2 * RW;
  localparam int NMAG_W = MAG_W + 3;
  localparam int SUM_W  = MAG_W + 4;
  localparam int NUM_W  = NMAG_W + FRAC_BITS;
  localparam int DEN_W  = MAG_W + 1;
  localparam int CMP_W  = (NUM_W > RES_W + 1) ? NUM_W : RES_W + 1;
  localparam int MC_W   = $clog2(MAG_W + 1);
  localparam logic [CMP_W-1:0] LIM_POS = CMP_W'(33'h0_7FFF_FFFF);
  localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(33'h0_8000_0000);

  state_t state, state_next;

  // Captured item.
  logic             deg2, lin_div, zl;
  logic [MAG_W-1:0] am, bm, cm;
  logic             an, bn, cn;

  // Serial products and discriminant.
  logic [PW-1:0]    p_bb, p_ac;
  logic [MC_W-1:0]  mcnt;
  logic [MAG_W:0]   s_bb, s_ac;
  logic [RAD_W-1:0] disc, disc_next;
  logic             dneg, dneg_next;

  // Square root and divider links.
  logic             sqrt_start, sqrt_done;
  logic [RW-1:0]    rt;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic [1:0]       sel;
  logic             div_neg, div_last;

  // Root figures and flags.
  logic signed [SUM_W-1:0] nb, rt_s, sum_p, sum_m;
  logic [NMAG_W-1:0]       mag_p, mag_m, div_mag;
  logic [CMP_W-1:0]        q_ext, lim;
  logic                    clamp;
  logic [RES_W-1:0]        mag32, res;
  logic [RES_W-1:0]        r1, r2, re, im;
  logic                    sat;
  logic                    out_load;
  logic [1:0]              count;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (eqn.valid) begin
          if (eqn.lead_magnitude == '0) begin
            state_next = ST_FINISH;
          end else if (eqn.degree_two) begin
            state_next = ST_MUL;
          end else if (eqn.term_count >= 2'd2) begin
            state_next = ST_DIV_GO;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_MUL:       if (mcnt == MC_W'(MAG_W - 1)) state_next = ST_DISC;
      ST_DISC:      state_next = ST_SQRT_GO;
      ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = div_last ? ST_FINISH : ST_DIV_GO;
      end
      ST_FINISH:    if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    eqn.ready  = state == ST_IDLE;
    sqrt_start = state == ST_SQRT_GO;
    div_start  = state == ST_DIV_GO;
    out_load   = (state == ST_FINISH) && (!roots.valid || roots.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Serial multiplier steps and discriminant.
  always_comb begin
    s_bb = {1'b0, p_bb[PW-1:MAG_W]} + (p_bb[0] ? {1'b0, bm} : '0);
    s_ac = {1'b0, p_ac[PW-1:MAG_W]} + (p_ac[0] ? {1'b0, am} : '0);
    disc_next = '0;
    dneg_next = 1'b0;
    if (an != cn) begin
      disc_next = RAD_W'(p_bb) + RAD_W'({p_ac, 2'b00});
    end else if (RAD_W'(p_bb) >= RAD_W'({p_ac, 2'b00})) begin
      disc_next = RAD_W'(p_bb) - RAD_W'({p_ac, 2'b00});
    end else begin
      disc_next = RAD_W'({p_ac, 2'b00}) - RAD_W'(p_bb);
      dneg_next = 1'b1;
    end
  end

  // Division operands for the figure selected.
  always_comb begin
    nb    = bn ? $signed(SUM_W'(bm)) : -$signed(SUM_W'(bm));
    rt_s  = $signed(SUM_W'(rt));
    sum_p = nb + rt_s;
    sum_m = nb - rt_s;
    mag_p = sum_p[SUM_W-1] ? NMAG_W'(-sum_p) : NMAG_W'(sum_p);
    mag_m = sum_m[SUM_W-1] ? NMAG_W'(-sum_m) : NMAG_W'(sum_m);
    div_den = deg2 ? {am, 1'b0} : {1'b0, am};
    if (!deg2) begin
      div_mag = NMAG_W'(bm);
      div_neg = (!bn) != an;
    end else begin
      case (sel)
        DIV_PLUS: begin
          div_mag = mag_p;
          div_neg = sum_p[SUM_W-1] != an;
        end
        DIV_MINUS: begin
          div_mag = mag_m;
          div_neg = sum_m[SUM_W-1] != an;
        end
        DIV_REAL: begin
          div_mag = NMAG_W'(bm);
          div_neg = ((bm != '0) && !bn) != an;
        end
        DIV_IMAG: begin
          div_mag = NMAG_W'(rt);
          div_neg = an;
        end
        default: begin
          div_mag = '0;
          div_neg = 1'b0;
        end
      endcase
    end
    div_num  = {div_mag, {FRAC_BITS{1'b0}}};
    div_last = !deg2 || (sel == DIV_IMAG) || ((sel == DIV_MINUS) && !dneg);
  end

  // Saturation and sign of a finished quotient.
  always_comb begin
    q_ext = CMP_W'(div_quo);
    lim   = div_neg ? LIM_NEG : LIM_POS;
    clamp = q_ext > lim;
    mag32 = clamp ? lim[RES_W-1:0] : q_ext[RES_W-1:0];
    res   = div_neg ? -mag32 : mag32;
  end

  // Item capture, products and root figures.
  always_ff @(posedge clk) begin
    if (eqn.valid && eqn.ready) begin
      deg2    <= eqn.degree_two;
      zl      <= eqn.lead_magnitude == '0;
      lin_div <= eqn.term_count >= 2'd2;
      am      <= eqn.lead_magnitude;
      an      <= eqn.lead_negative;
      bm      <= '0;
      bn      <= 1'b0;
      cm      <= '0;
      cn      <= 1'b0;
      if (!eqn.degree_two || eqn.term_count == 2'd3 ||
          (eqn.term_count == 2'd2 && eqn.second_power)) begin
        bm <= eqn.second_magnitude;
        bn <= eqn.second_negative;
      end else if (eqn.term_count == 2'd2) begin
        cm <= eqn.second_magnitude;
        cn <= eqn.second_negative;
      end
      if (eqn.degree_two && eqn.term_count == 2'd3) begin
        cm <= eqn.third_magnitude;
        cn <= eqn.third_negative;
      end
      // The multipliers start with b and c in the low halves.
      p_bb <= (!eqn.degree_two || eqn.term_count == 2'd3 ||
               (eqn.term_count == 2'd2 && eqn.second_power)) ?
              PW'(eqn.second_magnitude) : '0;
      p_ac <= !eqn.degree_two ? '0 :
              (eqn.term_count == 2'd3) ? PW'(eqn.third_magnitude) :
              (eqn.term_count == 2'd2 && !eqn.second_power) ?
              PW'(eqn.second_magnitude) : '0;
      mcnt <= '0;
      dneg <= 1'b0;
      sel  <= DIV_PLUS;
      sat  <= 1'b0;
      r1   <= '0;
      r2   <= '0;
      re   <= '0;
      im   <= '0;
    end else begin
      if (state == ST_MUL) begin
        p_bb <= {s_bb, p_bb[MAG_W-1:1]};
        p_ac <= {s_ac, p_ac[MAG_W-1:1]};
        mcnt <= mcnt + 1'b1;
      end
      if (state == ST_DISC) begin
        disc <= disc_next;
        dneg <= dneg_next;
      end
      if (state == ST_DIV_WAIT && div_done) begin
        sat <= sat | clamp;
        case (sel)
          DIV_PLUS: begin
            r1 <= res;
            if (!deg2) r2 <= res;
          end
          DIV_MINUS: r2 <= res;
          DIV_REAL:  re <= res;
          DIV_IMAG:  im <= res;
          default:   r1 <= res;
        endcase
        sel <= sel + 1'b1;
      end
    end
  end

  // Result register on the output channel.
  always_comb begin
    if (zl) begin
      count = SOL_NONE;
    end else if (!deg2) begin
      count = SOL_ONE;
    end else if (dneg) begin
      count = SOL_NONE;
    end else begin
      count = (rt == '0) ? SOL_ONE : SOL_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (out_load) begin
      roots.valid <= 1'b1;
    end else if (roots.ready) begin
      roots.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      roots.root_first     <= $signed(r1);
      roots.root_second    <= $signed(r2);
      roots.real_part      <= $signed(re);
      roots.imag_part      <= $signed(im);
      roots.complex_roots  <= deg2 && !zl && dneg;
      roots.solution_count <= count;
      roots.solved_degree  <= deg2 ? DEGREE_TWO : DEGREE_ONE;
      roots.zero_lead      <= zl;
      roots.saturated      <= sat && !zl && (deg2 || lin_div);
    end
  end

  qrs_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (disc),
    .done     (sqrt_done),
    .root     (rt)
  );

  qrs_div #(
    .NW (NUM_W),
    .DW (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

@@ tb/sv/quadratic_root_solver_chk.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_chk: root prediction and result checking
// Watches both item channels, computes the expected roots of every accepted
// equation and compares each accepted result with the oldest one waiting.
// ----------------------------------------------------------------------------
module quadratic_root_solver_chk import qrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  qrs_in_if    eqn,
  qrs_out_if   roots,
  output int   fail_count,
  output int   roots_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] root_first;
    logic signed [31:0] root_second;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
    logic               complex_roots;
    logic [1:0]         solution_count;
    logic [1:0]         solved_degree;
    logic               zero_lead;
    logic               saturated;
  } roots_t;

  roots_t expected_roots[$];

  // Scaled quotient mag * 2^16 / den, truncated toward zero, clamped to 32 bits.
  function automatic logic [31:0] scaled_quot(input logic [63:0] mag, input logic neg,
                                              input logic [63:0] den, inout logic sat);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] lim;
    num = {64'd0, mag} << 16;
    if (den == 0) return 32'd0;
    q = num / {64'd0, den};
    lim = neg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  // Truncated square root of a 128-bit value.
  function automatic logic [63:0] root_floor(input logic [127:0] d);
    logic [63:0] res;
    logic [63:0] cand;
    res = 0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      cand = res | (64'd1 << bit_i);
      if ({64'd0, cand} * {64'd0, cand} <= d) res = cand;
    end
    return res;
  endfunction

  // Magnitude and sign of -b plus or minus the root.
  function automatic void split_sum(input logic signed [67:0] v, output logic [63:0] mag,
                                    output logic neg);
    neg = v < 0;
    mag = neg ? 64'(-v) : 64'(v);
  endfunction

  // Expected result of one equation.
  function automatic roots_t solve_equation(input logic deg2, input logic [1:0] tc,
      input logic [30:0] am, input logic an, input logic [30:0] sm, input logic sn,
      input logic sp, input logic [30:0] tm, input logic tn);
    roots_t r;
    logic sat;
    logic [63:0] bm, cm, den, rt, m;
    logic bn, cn, dneg, ng;
    logic [127:0] bb, ac4, d;
    logic signed [67:0] nb;
    r = '0;
    sat = 1'b0;
    bm = 0; cm = 0; bn = 0; cn = 0;
    if (am != 0 && !deg2) begin
      r.solution_count = SOL_ONE;
      if (tc >= 2) begin
        r.root_first = scaled_quot({33'd0, sm}, (!sn) != an, {33'd0, am}, sat);
        r.root_second = r.root_first;
      end
    end else if (am != 0) begin
      den = {33'd0, am} << 1;
      if (tc == 2) begin
        if (sp) begin
          bm = {33'd0, sm}; bn = sn;
        end else begin
          cm = {33'd0, sm}; cn = sn;
        end
      end else if (tc == 3) begin
        bm = {33'd0, sm}; bn = sn; cm = {33'd0, tm}; cn = tn;
      end
      bb = {64'd0, bm} * {64'd0, bm};
      ac4 = ({64'd0, am} * {64'd0, cm}) << 2;
      if (an != cn) begin
        d = bb + ac4; dneg = 1'b0;
      end else if (bb >= ac4) begin
        d = bb - ac4; dneg = 1'b0;
      end else begin
        d = ac4 - bb; dneg = 1'b1;
      end
      rt = root_floor(d);
      nb = bn ? $signed({4'd0, bm}) : -$signed({4'd0, bm});
      split_sum(nb + $signed({4'd0, rt}), m, ng);
      r.root_first = scaled_quot(m, ng != an, den, sat);
      split_sum(nb - $signed({4'd0, rt}), m, ng);
      r.root_second = scaled_quot(m, ng != an, den, sat);
      if (dneg) begin
        r.complex_roots = 1'b1;
        r.real_part = scaled_quot(bm, (bm != 0 && !bn) != an, den, sat);
        r.imag_part = scaled_quot(rt, an, den, sat);
        r.solution_count = SOL_NONE;
      end else begin
        r.solution_count = (rt == 0) ? SOL_ONE : SOL_TWO;
      end
    end
    r.solved_degree = deg2 ? DEGREE_TWO : DEGREE_ONE;
    r.zero_lead = (am == 0);
    r.saturated = sat;
    return r;
  endfunction

  assign roots_pending = expected_roots.size();

  // Predict on every accepted equation, compare on every accepted result.
  always @(posedge clk) begin
    roots_t got;
    roots_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (eqn.valid && eqn.ready)
        expected_roots.push_back(solve_equation(eqn.degree_two, eqn.term_count,
          eqn.lead_magnitude, eqn.lead_negative, eqn.second_magnitude,
          eqn.second_negative, eqn.second_power, eqn.third_magnitude, eqn.third_negative));
      if (roots.valid && roots.ready) begin
        got = '{roots.root_first, roots.root_second, roots.real_part, roots.imag_part,
                roots.complex_roots, roots.solution_count, roots.solved_degree,
                roots.zero_lead, roots.saturated};
        if (expected_roots.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result item %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("Mismatch: expected r1=%h r2=%h re=%h im=%h c=%b n=%0d deg=%0d z=%b s=%b",
                       want.root_first, want.root_second, want.real_part, want.imag_part,
                       want.complex_roots, want.solution_count, want.solved_degree,
                       want.zero_lead, want.saturated);
              $display("          actual   r1=%h r2=%h re=%h im=%h c=%b n=%0d deg=%0d z=%b s=%b",
                       got.root_first, got.root_second, got.real_part, got.imag_part,
                       got.complex_roots, got.solution_count, got.solved_degree,
                       got.zero_lead, got.saturated);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/quadratic_root_solver_tb.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb: testbench top of the quadratic root solver
// Drives directed and random equations with random idling on both sides,
// one long receiver hold-off and one drain pause, then gives the verdict.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   roots_pending;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;

  qrs_in_if  eqn ();
  qrs_out_if roots ();

  quadratic_root_solver uut (.clk(clk), .rst(rst), .eqn(eqn), .roots(roots));

  quadratic_root_solver_chk chk (.clk(clk), .rst(rst), .eqn(eqn), .roots(roots),
                                 .fail_count(fail_count), .roots_pending(roots_pending));

  always #4 clk = ~clk;

  // Offer one equation and wait until it is accepted.
  task automatic send_equation(input logic deg2, input logic [1:0] tc,
      input logic [30:0] am, input logic an, input logic [30:0] sm, input logic sn,
      input logic sp, input logic [30:0] tm, input logic tn);
    if (!calm && $urandom_range(99) < 37) begin
      eqn.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    eqn.valid <= 1'b1;
    eqn.degree_two <= deg2;
    eqn.term_count <= tc;
    eqn.lead_magnitude <= am;
    eqn.lead_negative <= an;
    eqn.second_magnitude <= sm;
    eqn.second_negative <= sn;
    eqn.second_power <= sp;
    eqn.third_magnitude <= tm;
    eqn.third_negative <= tn;
    do @(posedge clk); while (!eqn.ready);
  endtask

  // Coefficient magnitude: extremes, small values or anything.
  function automatic logic [30:0] pick_magnitude();
    case ($urandom_range(9))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2, 3: return 31'($urandom_range(1, 32'h40000));
      4, 5: return 31'($urandom_range(1, 8)) << 16;
      default: return 31'($urandom);
    endcase
  endfunction

  // Receiver: random idling, a calm stretch, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      roots.ready <= 1'b0;
    end else if (hold_req) begin
      roots.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      roots.ready <= 1'b1;
    end else begin
      roots.ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((eqn.valid && eqn.ready) || (roots.valid && roots.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [30:0] am;
    eqn.valid <= 1'b0;
    eqn.degree_two <= 1'b0;
    eqn.term_count <= 2'd0;
    eqn.lead_magnitude <= '0;
    eqn.lead_negative <= 1'b0;
    eqn.second_magnitude <= '0;
    eqn.second_negative <= 1'b0;
    eqn.second_power <= 1'b0;
    eqn.third_magnitude <= '0;
    eqn.third_negative <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero lead, every term layout, repeated and complex roots, saturation.
    send_equation(1'b0, 2'd2, 31'd0, 1'b0, 31'h10000, 1'b1, 1'b1, 31'd5, 1'b0);
    send_equation(1'b1, 2'd3, 31'd0, 1'b1, 31'h10000, 1'b0, 1'b0, 31'h7fffffff, 1'b1);
    send_equation(1'b0, 2'd0, 31'h10000, 1'b0, 31'h30000, 1'b0, 1'b1, 31'd0, 1'b0);
    send_equation(1'b0, 2'd1, 31'h20000, 1'b1, 31'h30000, 1'b1, 1'b0, 31'd0, 1'b0);
    send_equation(1'b0, 2'd2, 31'h20000, 1'b0, 31'h30000, 1'b1, 1'b1, 31'd0, 1'b0);
    send_equation(1'b0, 2'd3, 31'h20000, 1'b1, 31'h30000, 1'b0, 1'b0, 31'h7fffffff, 1'b1);
    send_equation(1'b0, 2'd2, 31'd1, 1'b0, 31'h7fffffff, 1'b0, 1'b1, 31'd0, 1'b0);
    send_equation(1'b0, 2'd2, 31'd1, 1'b1, 31'h7fffffff, 1'b0, 1'b0, 31'd0, 1'b0);
    send_equation(1'b1, 2'd0, 31'h10000, 1'b0, 31'h50000, 1'b0, 1'b1, 31'h50000, 1'b0);
    send_equation(1'b1, 2'd1, 31'h10000, 1'b1, 31'h50000, 1'b1, 1'b0, 31'h50000, 1'b1);
    send_equation(1'b1, 2'd2, 31'h10000, 1'b0, 31'h40000, 1'b1, 1'b0, 31'd0, 1'b0);
    send_equation(1'b1, 2'd2, 31'h10000, 1'b0, 31'h40000, 1'b0, 1'b0, 31'd0, 1'b0);
    send_equation(1'b1, 2'd2, 31'h10000, 1'b1, 31'h30000, 1'b1, 1'b1, 31'd0, 1'b0);
    send_equation(1'b1, 2'd3, 31'h10000, 1'b0, 31'h20000, 1'b0, 1'b0, 31'h10000, 1'b0);
    send_equation(1'b1, 2'd3, 31'h10000, 1'b0, 31'h20000, 1'b1, 1'b1, 31'h50000, 1'b0);
    send_equation(1'b1, 2'd3, 31'h10000, 1'b1, 31'h30000, 1'b0, 1'b0, 31'h20000, 1'b1);
    send_equation(1'b1, 2'd3, 31'h10000, 1'b0, 31'h50000, 1'b0, 1'b0, 31'h60000, 1'b1);
    send_equation(1'b1, 2'd3, 31'd1, 1'b0, 31'h7fffffff, 1'b0, 1'b0, 31'h7fffffff, 1'b1);
    send_equation(1'b1, 2'd3, 31'd1, 1'b1, 31'h7fffffff, 1'b1, 1'b1, 31'h7fffffff, 1'b1);
    send_equation(1'b1, 2'd3, 31'h7fffffff, 1'b1, 31'h7fffffff, 1'b0, 1'b0, 31'h7fffffff,
                  1'b0);
    send_equation(1'b1, 2'd3, 31'h7fffffff, 1'b0, 31'd0, 1'b0, 1'b0, 31'd1, 1'b0);
    send_equation(1'b1, 2'd2, 31'd1, 1'b0, 31'h7fffffff, 1'b1, 1'b0, 31'd0, 1'b0);

    // Random equations, mostly with a nonzero lead.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) calm <= 1'b1;
      if (i == 400) calm <= 1'b0;
      if (i == 700) hold_req <= 1'b1;
      if (i == 701) hold_req <= 1'b0;
      if (i == 1100) begin
        eqn.valid <= 1'b0;
        do @(posedge clk); while (roots_pending != 0);
      end
      am = pick_magnitude();
      if (am == 0 && $urandom_range(3) != 0) am = 31'($urandom_range(1, 32'h80000));
      send_equation(1'($urandom), 2'($urandom), am, 1'($urandom), pick_magnitude(),
                    1'($urandom), 1'($urandom), pick_magnitude(), 1'($urandom));
    end
    eqn.valid <= 1'b0;

    // Drain, then allow the longest solve to pass.
    do @(posedge clk); while (roots_pending != 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && roots_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
